### design/signed_int_to_decimal_chars_macros.svh
// ----------------------------------------------------------------------------
// signed_int_to_decimal_chars assertion macros
// shared property wrappers for the checker, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_CHARS_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_CHARS_MACROS_SVH

// property holds in the same cycle once out of reset
`define SIDC_ASSERT(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SIDC_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### design/sidc_pkg.sv
// ----------------------------------------------------------------------------
// sidc_pkg
// shared types, character codes and power-of-ten table for the converter
// ----------------------------------------------------------------------------
package sidc_pkg;

  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

  // one character beat between front and back
  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    logic              last;
  } char_beat_t;

  // mult * 10^pos, wide enough for 9 * 10^9
  function automatic logic [33:0] pow10_mul(input logic [3:0] pos, input logic [3:0] mult);
    logic [33:0] p;
    unique case (pos)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = 34'd0;
    endcase
    return p * {30'd0, mult};
  endfunction

endpackage

### design/signed_int_to_decimal_chars.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_chars: 32-bit signed integer to decimal ascii beats
// a new value is taken only while idle, after the last digit of the one before
// the digit loop sets the pace and stalls only while the queue is full
// synchronous active-low reset empties the queue and idles both parts
// ----------------------------------------------------------------------------
module signed_int_to_decimal_chars (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [31:0]            in_value,
  output logic                          out_strobe,
  output logic [sidc_pkg::CHAR_W-1:0]   out_ascii_char,
  output logic                          out_last
);
  import sidc_pkg::*;

  // front to queue
  logic       push;
  char_beat_t push_beat;
  logic       q_full;

  // queue to back
  logic       pop;
  logic       q_empty;
  char_beat_t head_beat;

  // front: takes a value when idle, forms the magnitude, then walks the
  // ten decimal positions from 10^9 down, one per cycle unless q_full,
  // dropping leading zeros; a negative value puts a minus beat out first
  sidc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_value  (in_value),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_beat (push_beat)
  );

  // queue: lets the front finish a value while the back still drains,
  // and stalls the front only if it ever fills up
  sidc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_beat (push_beat),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head_beat (head_beat)
  );

  // back: one beat per cycle onto the strobed result ports
  sidc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .head_beat      (head_beat),
    .pop            (pop),
    .out_strobe     (out_strobe),
    .out_ascii_char (out_ascii_char),
    .out_last       (out_last)
  );

endmodule

### design/sidc_front.sv
// ----------------------------------------------------------------------------
// sidc_front
// accepts a value, minus if negative, one digit per unstalled cycle msd first
// ----------------------------------------------------------------------------
module sidc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [31:0]            in_value,
  input  logic                   q_full,
  output logic                   busy,
  output logic                   push,
  output sidc_pkg::char_beat_t   push_beat
);
  import sidc_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_SIGN, F_DIGIT} front_state_t;

  front_state_t state_r, state_nxt;
  logic [31:0]  mag_r, mag_nxt;
  logic [3:0]   pos_r, pos_nxt;
  logic         lead_r, lead_nxt;

  logic [3:0]   digit;
  logic [31:0]  rem;
  logic         emit;

  assign busy = (state_r != F_IDLE);

  // nine trial subtractions in parallel, keep the largest one that fits
  always_comb begin
    logic [34:0] diff;
    digit = 4'd0;
    rem   = mag_r;
    for (int c = 1; c <= 9; c++) begin
      diff = {3'b000, mag_r} - {1'b0, pow10_mul(pos_r, 4'(c))};
      if (!diff[34]) begin
        digit = 4'(c);
        rem   = diff[31:0];
      end
    end
  end

  // leading zeros are dropped, the units digit always goes out
  assign emit = (digit != 4'd0) || lead_r || (pos_r == 4'd0);

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    pos_nxt   = pos_r;
    lead_nxt  = lead_r;
    push      = 1'b0;
    push_beat = '{ascii_char: CH_ZERO + {2'b00, digit}, last: (pos_r == 4'd0)};
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          mag_nxt   = in_value[31] ? (~in_value + 32'd1) : in_value;
          pos_nxt   = 4'd9;
          lead_nxt  = 1'b0;
          state_nxt = in_value[31] ? F_SIGN : F_DIGIT;
        end
      end
      F_SIGN: begin
        push_beat = '{ascii_char: CH_MINUS, last: 1'b0};
        if (!q_full) begin
          push      = 1'b1;
          state_nxt = F_DIGIT;
        end
      end
      F_DIGIT: begin
        if (!q_full) begin
          push     = emit;
          mag_nxt  = rem;
          lead_nxt = lead_r | emit;
          if (pos_r == 4'd0) begin
            state_nxt = F_IDLE;
          end else begin
            pos_nxt = pos_r - 4'd1;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    pos_r  <= pos_nxt;
    lead_r <= lead_nxt;
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/sidc_queue.sv
// ----------------------------------------------------------------------------
// sidc_queue
// small character queue between the digit front and the output back
// ----------------------------------------------------------------------------
module sidc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sidc_pkg::char_beat_t push_beat,
  input  logic                 pop,
  output logic                 full,
  output logic                 empty,
  output sidc_pkg::char_beat_t head_beat
);
  import sidc_pkg::*;

  char_beat_t          entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign empty     = (count_r == '0);
  assign head_beat = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### design/sidc_back.sv
// ----------------------------------------------------------------------------
// sidc_back
// drains the queue one beat per cycle into the registered result ports
// ----------------------------------------------------------------------------
module sidc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  sidc_pkg::char_beat_t          head_beat,
  output logic                          pop,
  output logic                          out_strobe,
  output logic [sidc_pkg::CHAR_W-1:0]   out_ascii_char,
  output logic                          out_last
);
  import sidc_pkg::*;

  logic              strobe_r;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;

  // receiver cannot stall, so any queued beat leaves right away
  assign pop = !q_empty;

  always_ff @(posedge clk) begin
    char_r <= head_beat.ascii_char;
    last_r <= head_beat.last;
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= pop;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_ascii_char = char_r;
  assign out_last       = last_r;

endmodule

### design/sidc_checker.sv
// ----------------------------------------------------------------------------
// sidc_checker
// port-level checks on the converter, bound to the top level
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_chars_macros.svh"

module sidc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic [sidc_pkg::CHAR_W-1:0]   out_ascii_char,
  input logic                          out_last
);
  import sidc_pkg::*;

  // every beat is a minus sign or a digit
  `SIDC_ASSERT(a_char_legal, clk, rst_n, !out_strobe || (out_ascii_char == CH_MINUS) || ((out_ascii_char >= CH_ZERO) && (out_ascii_char <= CH_ZERO + 6'd9)), "beat is not a digit or minus")

  // a minus sign never ends a number
  `SIDC_ASSERT(a_minus_not_last, clk, rst_n, !(out_strobe && (out_ascii_char == CH_MINUS) && out_last), "minus beat marked last")

  // an accepted value keeps the block busy in the next cycle
  `SIDC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy not raised after accept")

  // busy only rises after an accept
  `SIDC_ASSERT(a_busy_cause, clk, rst_n, !$rose(busy) || ($past(start) && !$past(busy)), "busy rose without accept")

endmodule

bind signed_int_to_decimal_chars sidc_checker u_sidc_checker (.*);
